>>> rtl/vector_reduction_dot_asum_norm_defines.svh
// Assertion macros for the vector reduction block.
`ifndef VECTOR_REDUCTION_DOT_ASUM_NORM_DEFINES_SVH
`define VECTOR_REDUCTION_DOT_ASUM_NORM_DEFINES_SVH

`ifndef SYNTHESIS
`define VRD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vrd check failed");
`define VRD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vrd check failed");
`else
`define VRD_ASSERT_IMP(lbl, ante, cons)
`define VRD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> rtl/vrd_pkg.sv
// Shared types and constants of the vector reduction block.
package vrd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int ACC_W      = 48;
  localparam int BIAS_W     = 48;
  localparam int NORM_W     = 24;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = (BIAS_W > MODE_W) ? BIAS_W : MODE_W;
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int TERM_W     = PROD_W + 1;
  localparam int SUM_BASE_W = (ACC_W > TERM_W) ? ACC_W : TERM_W;
  localparam int SUM_W      = ((SUM_BASE_W > BIAS_W) ? SUM_BASE_W : BIAS_W) + 1;
  localparam int ROOT_W     = (ACC_W + 1) / 2;
  localparam int CMP_W      = (ROOT_W > NORM_W) ? ROOT_W : NORM_W;
  localparam int CNT_W      = $clog2(ROOT_W);

  localparam logic [CFG_IDX_W-1:0] REG_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BIAS = CFG_IDX_W'(1);

  typedef enum logic [MODE_W-1:0] {
    MODE_ASUM = 2'd0,
    MODE_DOTU = 2'd1,
    MODE_DOTC = 2'd2,
    MODE_NRM2 = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_FIN,
    ST_SQRT,
    ST_OUT
  } st_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic acc;
    logic fin;
    logic sqrt_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic norm;
  } sts_t;

endpackage

>>> rtl/vrd_ctrl.sv
// Controller state machine of the vector reduction block.
module vrd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          out_ready,
  input  vrd_pkg::sts_t sts,
  output logic          in_ready,
  output logic          out_valid,
  output vrd_pkg::cmd_t cmd,
  output vrd_pkg::st_t  state
);
  import vrd_pkg::*;

  st_t              state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.last ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        cnt_nxt   = CNT_W'(ROOT_W - 1);
        state_nxt = sts.norm ? ST_SQRT : ST_OUT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_OUT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = cmd.out_load | (out_valid_r & ~out_ready);
  end

  assign out_valid = out_valid_r;
  assign state     = state_r;

endmodule

>>> rtl/vrd_dp.sv
// Datapath of the vector reduction block: registers, products, accumulators, root.
module vrd_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  vrd_pkg::cmd_t                         cmd,
  output vrd_pkg::sts_t                         sts,
  input  logic                                  cfg_we,
  input  logic        [vrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [vrd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic signed [vrd_pkg::SAMPLE_W-1:0]   x_re,
  input  logic signed [vrd_pkg::SAMPLE_W-1:0]   x_im,
  input  logic signed [vrd_pkg::SAMPLE_W-1:0]   y_re,
  input  logic signed [vrd_pkg::SAMPLE_W-1:0]   y_im,
  input  logic                                  last,
  output logic signed [vrd_pkg::ACC_W-1:0]      sum_re,
  output logic signed [vrd_pkg::ACC_W-1:0]      sum_im,
  output logic        [vrd_pkg::NORM_W-1:0]     norm,
  output logic                                  overflow
);
  import vrd_pkg::*;

  localparam logic signed [ACC_W-1:0] ACC_HI = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_LO = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [NORM_W-1:0]       NORM_MAX = '1;

  typedef struct packed {
    logic signed [ACC_W-1:0] val;
    logic                    sat;
  } sat_t;

  function automatic sat_t sat_clamp(input logic signed [SUM_W-1:0] s);
    sat_t r;
    logic [SUM_W-ACC_W:0] top;
    top = s[SUM_W-1:ACC_W-1];
    r.sat = !((&top) || !(|top));
    if (r.sat) begin
      r.val = s[SUM_W-1] ? ACC_LO : ACC_HI;
    end else begin
      r.val = s[ACC_W-1:0];
    end
    return r;
  endfunction

  mode_t                    mode_r;
  logic signed [BIAS_W-1:0] bias_r;

  logic signed [SAMPLE_W-1:0] xr_r, xi_r, yr_r, yi_r;
  logic                       last_r;
  logic signed [PROD_W-1:0]   p0_r, p1_r, p2_r, p3_r;
  logic signed [TERM_W-1:0]   abs_r;

  logic signed [ACC_W-1:0] acc_re_r, acc_im_r;
  logic                    sat_r;

  logic signed [ACC_W-1:0] res_re_r, res_im_r;
  logic                    res_ovf_r;

  logic [2*ROOT_W-1:0] rad_r;
  logic [ROOT_W+1:0]   rem_r;
  logic [ROOT_W-1:0]   root_r;

  logic signed [ACC_W-1:0]  out_re_r, out_im_r;
  logic [NORM_W-1:0]        out_norm_r;
  logic                     out_ovf_r;

  logic signed [SAMPLE_W-1:0] mb0, mb1;
  logic signed [TERM_W-1:0]   ax_r, ax_i;
  logic signed [TERM_W-1:0]   term_re, term_im;
  logic                       upd_im;
  sat_t                       add_re, add_im, add_bias;
  logic                       is_dot;
  logic [ROOT_W+1:0]          rem_sh, trial;
  logic [NORM_W-1:0]          norm_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ASUM;
      bias_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE: mode_r <= mode_t'(cfg_data[MODE_W-1:0]);
        REG_BIAS: bias_r <= cfg_data[BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  assign is_dot   = (mode_r == MODE_DOTU) || (mode_r == MODE_DOTC);
  assign sts.last = last_r;
  assign sts.norm = (mode_r == MODE_NRM2);

  always_comb begin
    mb0  = (mode_r == MODE_NRM2) ? xr_r : yr_r;
    mb1  = (mode_r == MODE_NRM2) ? xi_r : yi_r;
    ax_r = (xr_r < 0) ? -TERM_W'(xr_r) : TERM_W'(xr_r);
    ax_i = (xi_r < 0) ? -TERM_W'(xi_r) : TERM_W'(xi_r);
  end

  always_comb begin
    upd_im = 1'b0;
    term_im = '0;
    case (mode_r)
      MODE_ASUM: term_re = abs_r;
      MODE_DOTU: begin
        term_re = TERM_W'(p0_r) - TERM_W'(p1_r);
        term_im = TERM_W'(p2_r) + TERM_W'(p3_r);
        upd_im  = 1'b1;
      end
      MODE_DOTC: begin
        term_re = TERM_W'(p0_r) + TERM_W'(p1_r);
        term_im = TERM_W'(p2_r) - TERM_W'(p3_r);
        upd_im  = 1'b1;
      end
      MODE_NRM2: term_re = TERM_W'(p0_r) + TERM_W'(p1_r);
      default:   term_re = '0;
    endcase
    add_re   = sat_clamp(SUM_W'(acc_re_r) + SUM_W'(term_re));
    add_im   = sat_clamp(SUM_W'(acc_im_r) + SUM_W'(term_im));
    add_bias = sat_clamp(SUM_W'(acc_re_r) + SUM_W'(bias_r));
  end

  always_comb begin
    rem_sh = {rem_r[ROOT_W-1:0], rad_r[2*ROOT_W-1 -: 2]};
    trial  = {root_r, 2'b01};
    if (CMP_W'(root_r) > CMP_W'(NORM_MAX)) begin
      norm_val = NORM_MAX;
    end else begin
      norm_val = NORM_W'(root_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      xr_r   <= x_re;
      xi_r   <= x_im;
      yr_r   <= y_re;
      yi_r   <= y_im;
      last_r <= last;
    end
    if (cmd.mul) begin
      p0_r  <= xr_r * mb0;
      p1_r  <= xi_r * mb1;
      p2_r  <= xr_r * yi_r;
      p3_r  <= yr_r * xi_r;
      abs_r <= ax_r + ax_i;
    end
    if (cmd.fin) begin
      res_re_r  <= is_dot ? add_bias.val : acc_re_r;
      res_im_r  <= is_dot ? acc_im_r : '0;
      res_ovf_r <= sat_r | (is_dot & add_bias.sat);
      rad_r     <= (sts.norm && acc_re_r > 0) ? (2*ROOT_W)'(unsigned'(acc_re_r)) : '0;
      rem_r     <= '0;
      root_r    <= '0;
    end else if (cmd.sqrt_step) begin
      rad_r <= rad_r << 2;
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      out_re_r   <= res_re_r;
      out_im_r   <= res_im_r;
      out_norm_r <= norm_val;
      out_ovf_r  <= res_ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
      sat_r    <= 1'b0;
    end else if (cmd.fin) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
      sat_r    <= 1'b0;
    end else if (cmd.acc) begin
      acc_re_r <= add_re.val;
      if (upd_im) begin
        acc_im_r <= add_im.val;
      end
      sat_r <= sat_r | add_re.sat | (upd_im & add_im.sat);
    end
  end

  assign sum_re   = out_re_r;
  assign sum_im   = out_im_r;
  assign norm     = out_norm_r;
  assign overflow = out_ovf_r;

endmodule

>>> rtl/vector_reduction_dot_asum_norm.sv
// Vector reduction top level (absolute sum, unconjugated and conjugated dot, two-norm)
// over a stream of complex Q1.15 element pairs; one result per vector, on the item with
// last set. Each item is captured in the idle state and then passes through the multiply
// and accumulate states; no new item is taken until the block is back in idle. An item
// with last set adds a finishing state (bias add in the dot modes, result capture,
// accumulator clear), in norm mode the bit-serial square root (one root bit per
// cycle), then an output state that loads the output register; that register
// lets the next vector start while the result waits. Configuration writes are taken
// in every cycle and must only be issued while the block is idle.
`include "vector_reduction_dot_asum_norm_defines.svh"

module vector_reduction_dot_asum_norm (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic        [vrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [vrd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [vrd_pkg::SAMPLE_W-1:0]   in_x_re,
  input  logic signed [vrd_pkg::SAMPLE_W-1:0]   in_x_im,
  input  logic signed [vrd_pkg::SAMPLE_W-1:0]   in_y_re,
  input  logic signed [vrd_pkg::SAMPLE_W-1:0]   in_y_im,
  input  logic                                  in_last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [vrd_pkg::ACC_W-1:0]      out_sum_re,
  output logic signed [vrd_pkg::ACC_W-1:0]      out_sum_im,
  output logic        [vrd_pkg::NORM_W-1:0]     out_norm,
  output logic                                  out_overflow
);
  import vrd_pkg::*;

  cmd_t cmd;
  sts_t sts;
  st_t  state;

  assign cfg_ready = 1'b1;

  vrd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd),
    .state     (state)
  );

  vrd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .x_re      (in_x_re),
    .x_im      (in_x_im),
    .y_re      (in_y_re),
    .y_im      (in_y_im),
    .last      (in_last),
    .sum_re    (out_sum_re),
    .sum_im    (out_sum_im),
    .norm      (out_norm),
    .overflow  (out_overflow)
  );

  `VRD_ASSERT_NXT(a_one_request_in_flight, in_valid && in_ready, !in_ready)
  `VRD_ASSERT_IMP(a_result_from_out_state, $rose(out_valid), $past(state == ST_OUT))
  `VRD_ASSERT_NXT(a_root_ends_in_out, state == ST_SQRT, state == ST_SQRT || state == ST_OUT)

endmodule
